FILE: hw/rtl/mlcd_pkg.sv
// Shared types and constants for the memory LCD frame store and refresh unit.
// Holds the panel geometry, the command codes, the item structs and the RAM request struct.
// No dependencies.
package mlcd_pkg;

  // Panel geometry and the frame store that follows from it.
  localparam int PANEL_WIDTH  = 144;
  localparam int PANEL_HEIGHT = 168;
  localparam int LINE_BYTES   = PANEL_WIDTH / 8;
  localparam int STORE_BYTES  = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int PIX_W        = $clog2(PANEL_WIDTH * PANEL_HEIGHT);
  localparam int LCNT_W       = $clog2(LINE_BYTES + 1);

  // Mode byte flags for a refresh.
  localparam logic [7:0] MODE_WRITE = 8'h80;
  localparam int         VCOM_POS   = 6;

  typedef enum logic [1:0] {
    CMD_WRITE_PIXEL = 2'd0,
    CMD_CLEAR       = 2'd1,
    CMD_REFRESH     = 2'd2,
    CMD_SEND_LINE   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] column;
    logic [7:0] row;
    logic       pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last;
    logic       status;
  } out_item_t;

  // One write port and one read port of the frame RAM.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

FILE: hw/rtl/mlcd_frame_ram.sv
// Frame store RAM: one byte per entry, one write and one read port, registered read data.
// Depends on mlcd_pkg for the depth and the request struct.
module mlcd_frame_ram
  import mlcd_pkg::*;
(
  input  logic       clk_i,
  input  ram_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [STORE_BYTES];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/memory_lcd_frame_store_and_refresh_unit.sv
// Top level of the memory LCD frame store and refresh unit.
// Depends on mlcd_pkg and instantiates mlcd_frame_ram.

// The unit keeps a one-bit-per-pixel frame in a single-port-read, single-port-write RAM
// and handles one item at a time. A pixel write steps through a read, then a modify and
// write back together with the result, then idle; a refresh or a rejected coordinate goes
// straight to its result; and a line send gives a header, LINE_BYTES data bytes paced at
// one byte per cycle by the RAM read port, and a trailer. A stalled output stretches any of
// these. After reset, and for every clear command, the unit sweeps zeros through all
// STORE_BYTES entries of the RAM at one byte per cycle and accepts no item meanwhile; the
// configuration register may be written at any time. Results leave through an output
// register, so a new item is taken while the final result of the previous one still waits.
module memory_lcd_frame_store_and_refresh_unit
  import mlcd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RESP,
    ST_LINE_HDR,
    ST_LINE_DAT,
    ST_LINE_TRL
  } state_e;

  state_e            state_q;
  logic              draw_invert_q;
  logic              vcom_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [7:0]        row_q;
  logic [7:0]        column_q;
  logic              set_q;
  logic [ADDR_W-1:0] pix_addr_q;
  logic [7:0]        pix_mask_q;
  logic [ADDR_W-1:0] line_addr_q;
  logic [LCNT_W-1:0] byte_cnt_q;
  logic [7:0]        resp_byte_q;
  logic              resp_status_q;
  logic              out_valid_q;
  out_item_t         out_item_q;

  ram_req_t          ram_req;
  logic [7:0]        ram_rdata;
  logic              accept;
  logic              out_free;
  logic              col_bad;
  logic              row_bad;
  logic [PIX_W-1:0]  pix_n;
  logic [7:0]        hdr_byte;
  logic [7:0]        row_inc;
  logic [ADDR_W-1:0] line_base;

  // Reverses the bit order of a byte for the line address.
  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Range checks and line set-up for an incoming item.
  assign col_bad   = {1'b0, in_item_i.column} >= 9'(PANEL_WIDTH);
  assign row_bad   = {1'b0, in_item_i.row} >= 9'(PANEL_HEIGHT);
  assign row_inc   = in_item_i.row + 8'd1;
  assign hdr_byte  = bit_rev8(row_inc);
  assign line_base = ADDR_W'(in_item_i.row) * ADDR_W'(LINE_BYTES);

  // Linear pixel index of the stored coordinate.
  assign pix_n = PIX_W'(row_q) * PIX_W'(PANEL_WIDTH) + PIX_W'(column_q);

  // RAM requests for each phase of the work.
  always_comb begin
    ram_req = '0;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt_q;
        ram_req.wdata = 8'h00;
      end
      ST_PIX_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = ADDR_W'(pix_n >> 3);
      end
      ST_PIX_WR: begin
        ram_req.we    = out_free;
        ram_req.waddr = pix_addr_q;
        ram_req.wdata = set_q ? (ram_rdata | pix_mask_q) : (ram_rdata & ~pix_mask_q);
      end
      ST_LINE_HDR: begin
        ram_req.re    = out_free;
        ram_req.raddr = line_addr_q;
      end
      ST_LINE_DAT: begin
        ram_req.re    = out_free && (byte_cnt_q != LCNT_W'(LINE_BYTES - 1));
        ram_req.raddr = line_addr_q;
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  mlcd_frame_ram u_frame_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_invert_q <= 1'b0;
    end else if (cfg_we_i) begin
      draw_invert_q <= cfg_wdata_i;
    end
  end

  // Sequencer: state, VCOM, work registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      vcom_q      <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT, ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
          if (clr_cnt_q == ADDR_W'(STORE_BYTES - 1)) begin
            clr_cnt_q     <= '0;
            resp_byte_q   <= 8'h00;
            resp_status_q <= 1'b0;
            state_q       <= (state_q == ST_CLEAR) ? ST_RESP : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            row_q         <= in_item_i.row;
            column_q      <= in_item_i.column;
            set_q         <= in_item_i.pixel_value ^ draw_invert_q;
            line_addr_q   <= line_base;
            byte_cnt_q    <= '0;
            resp_byte_q   <= 8'h00;
            resp_status_q <= 1'b0;
            case (in_item_i.command)
              CMD_WRITE_PIXEL: begin
                if (col_bad || row_bad) begin
                  resp_status_q <= 1'b1;
                  state_q       <= ST_RESP;
                end else begin
                  state_q <= ST_PIX_RD;
                end
              end
              CMD_CLEAR: begin
                state_q <= ST_CLEAR;
              end
              CMD_REFRESH: begin
                vcom_q      <= !vcom_q;
                resp_byte_q <= MODE_WRITE | (8'(!vcom_q) << VCOM_POS);
                state_q     <= ST_RESP;
              end
              CMD_SEND_LINE: begin
                if (row_bad) begin
                  resp_status_q <= 1'b1;
                  state_q       <= ST_RESP;
                end else begin
                  resp_byte_q <= hdr_byte;
                  state_q     <= ST_LINE_HDR;
                end
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_PIX_RD: begin
          pix_addr_q <= ADDR_W'(pix_n >> 3);
          pix_mask_q <= 8'h80 >> pix_n[2:0];
          state_q    <= ST_PIX_WR;
        end
        ST_PIX_WR: begin
          // The byte is written back together with the result, so the next item
          // cannot read it before the update lands.
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_item_q  <= '{byte_out: 8'h00, last: 1'b1, status: 1'b0};
            state_q     <= ST_IDLE;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_item_q  <= '{byte_out: resp_byte_q, last: 1'b1, status: resp_status_q};
            state_q     <= ST_IDLE;
          end
        end
        ST_LINE_HDR: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_item_q  <= '{byte_out: resp_byte_q, last: 1'b0, status: 1'b0};
            line_addr_q <= line_addr_q + ADDR_W'(1);
            state_q     <= ST_LINE_DAT;
          end
        end
        ST_LINE_DAT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_item_q  <= '{byte_out: ram_rdata, last: 1'b0, status: 1'b0};
            line_addr_q <= line_addr_q + ADDR_W'(1);
            byte_cnt_q  <= byte_cnt_q + LCNT_W'(1);
            if (byte_cnt_q == LCNT_W'(LINE_BYTES - 1)) begin
              state_q <= ST_LINE_TRL;
            end
          end
        end
        ST_LINE_TRL: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_item_q  <= '{byte_out: 8'h00, last: 1'b1, status: 1'b0};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The RAM is never read and written at the same entry in one cycle.
  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re && (ram_req.waddr == ram_req.raddr)))
    else $error("frame RAM read and write collide on one entry");

  // An accepted item keeps the unit busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("unit took an item without going busy");

  // A range error is always a single, final result with a zero byte.
  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status) |-> (out_item_o.last && (out_item_o.byte_out == 8'h00)))
    else $error("error result is not a lone zero item");

  // The clearing sweep writes while never presenting a new result.
  a_sweep_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_INIT) || (state_q == ST_CLEAR)) |=> !$rose(out_valid_o))
    else $error("result raised during clearing sweep");

endmodule
